### hdl/sxfp_pkg.sv
// Shared types and constants of the sync/XOR frame parser.
package sxfp_pkg;

   localparam logic [7:0] SYNC_BYTE   = 8'hBB;
   localparam int         PAYLOAD_LEN = 12;
   localparam int         POS_W       = $clog2(PAYLOAD_LEN);
   localparam int         QPTR_W      = 2;
   localparam int         QUEUE_DEPTH = 1 << QPTR_W;
   localparam int         QCNT_W      = QPTR_W + 1;

   // work handed from the front to the back
   typedef enum logic {
      OP_STORE = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   pos;
      logic [7:0]         data;
   } queue_item_type;

endpackage

### hdl/sxfp_front.sv
// Front part: header hunt and byte classification.
module sxfp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_rx_byte,
   input  logic                    req_buffer_last,
   input  logic                    q_full,
   output logic                    push_valid,
   output sxfp_pkg::queue_item_type push_item
);

   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_DONE    = 2'd2
   } mode_type;

   mode_type                        mode_ff, mode_in;
   logic                            prev_sync_ff, prev_sync_in;
   logic [sxfp_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                            accept;
   logic                            is_sync;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign is_sync   = (req_rx_byte == sxfp_pkg::SYNC_BYTE);

   always_comb begin
      mode_in        = mode_ff;
      prev_sync_in   = prev_sync_ff;
      pos_in         = pos_ff;
      push_valid     = 1'b0;
      push_item.op   = sxfp_pkg::OP_STORE;
      push_item.pos  = pos_ff;
      push_item.data = req_rx_byte;
      if (accept) begin
         case (mode_ff)
            MODE_HUNT: begin
               if (is_sync && prev_sync_ff) begin
                  mode_in      = MODE_COLLECT;
                  prev_sync_in = 1'b0;
                  pos_in       = '0;
               end else begin
                  prev_sync_in = is_sync;
               end
            end
            MODE_COLLECT: begin
               push_valid = 1'b1;
               if (pos_ff < sxfp_pkg::POS_W'(sxfp_pkg::PAYLOAD_LEN)) begin
                  pos_in = pos_ff + 1'b1;
               end else begin
                  push_item.op = sxfp_pkg::OP_CHECK;
                  mode_in      = MODE_DONE;
               end
            end
            default: begin
               // rest of the buffer is dropped
            end
         endcase
         if (req_buffer_last) begin
            mode_in      = MODE_HUNT;
            prev_sync_in = 1'b0;
            pos_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_HUNT;
         prev_sync_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         mode_ff      <= mode_in;
         prev_sync_ff <= prev_sync_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

### hdl/sxfp_queue.sv
// Short FIFO between front and back.
module sxfp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  sxfp_pkg::queue_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output sxfp_pkg::queue_item_type pop_item
);

   sxfp_pkg::queue_item_type         slot_ff [sxfp_pkg::QUEUE_DEPTH];
   logic [sxfp_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sxfp_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sxfp_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == sxfp_pkg::QCNT_W'(sxfp_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // front only offers work when there is room
   assert property (@(posedge clock) disable iff (reset) !(push_valid && full))
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= sxfp_pkg::QCNT_W'(sxfp_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[sxfp_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

### hdl/sxfp_back.sv
// Back part: payload store, running XOR and result register.
module sxfp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  sxfp_pkg::queue_item_type q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_frame_ok,
   output logic [31:0]              rsp_linear_x_word,
   output logic [31:0]              rsp_linear_y_word,
   output logic [31:0]              rsp_angular_word
);

   logic [7:0]   payload_ff [sxfp_pkg::PAYLOAD_LEN];
   logic [7:0]   xor_ff, xor_in;
   logic         rsp_valid_ff;
   logic         ok_ff;
   logic [31:0]  lin_x_ff, lin_y_ff, ang_ff;
   logic         out_free;
   logic         do_store;
   logic         do_check;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign do_store = q_valid && (q_item.op == sxfp_pkg::OP_STORE);
   assign do_check = q_valid && (q_item.op == sxfp_pkg::OP_CHECK) && out_free;
   assign q_pop    = do_store || do_check;

   // first payload byte restarts the checksum
   assign xor_in = ((q_item.pos == '0) ? 8'h00 : xor_ff) ^ q_item.data;

   always_ff @(posedge clock) begin
      if (do_store) begin
         payload_ff[q_item.pos] <= q_item.data;
         xor_ff                 <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= do_check;
      end
   end

   always_ff @(posedge clock) begin
      if (do_check) begin
         ok_ff    <= (xor_ff == q_item.data);
         lin_x_ff <= {payload_ff[3], payload_ff[2], payload_ff[1], payload_ff[0]};
         lin_y_ff <= {payload_ff[7], payload_ff[6], payload_ff[5], payload_ff[4]};
         ang_ff   <= {payload_ff[11], payload_ff[10], payload_ff[9], payload_ff[8]};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_ok      = ok_ff;
   assign rsp_linear_x_word = lin_x_ff;
   assign rsp_linear_y_word = lin_y_ff;
   assign rsp_angular_word  = ang_ff;

   // a check is only taken when the result slot can hold it
   assert property (@(posedge clock) disable iff (reset) do_check |=> rsp_valid_ff)
      else $error("check popped without a result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !do_check) |=> rsp_valid_ff)
      else $error("stalled result dropped");

   assert property (@(posedge clock) disable iff (reset)
      do_store |-> (q_item.pos < sxfp_pkg::POS_W'(sxfp_pkg::PAYLOAD_LEN)))
      else $error("payload index out of range");

endmodule

### hdl/sync_xor_frame_parser.sv
// Top level of the sync/XOR frame parser.
//
// Request channel (req_*): one received byte per request plus a flag that
// marks the last byte of a receive buffer. A request is taken at a clock
// edge where req_valid is high and req_stall is low.
// Within each buffer the parser hunts for the first 0xBB 0xBB header,
// collects the twelve payload bytes and the checksum byte after it, and
// emits one response (rsp_*): checksum flag plus three little-endian
// words. Later bytes of the same buffer are ignored; the buffer-end flag
// always restarts the hunt, dropping any partial frame.
// Throughput: one request per cycle while req_stall is low. The front
// classifies each byte in the cycle it is taken; a four-entry queue
// feeds the back, which stores one payload byte or, while no response
// is stalled, finishes one frame per cycle. The checksum byte is written
// into the queue when taken; the back then loads the result register.
// When the receiver holds rsp_stall the response is held steady; the back
// keeps storing payload bytes, and req_stall rises only once the queue
// fills behind a pending frame check.
// Reset (synchronous, active high) empties the queue, drops any pending
// response and returns the front to hunting.
module sync_xor_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_buffer_last,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_frame_ok,
   output logic [31:0]  rsp_linear_x_word,
   output logic [31:0]  rsp_linear_y_word,
   output logic [31:0]  rsp_angular_word
);

   // front -> queue
   logic                     push_valid;
   sxfp_pkg::queue_item_type push_item;
   logic                     q_full;

   // queue -> back
   logic                     q_valid;
   sxfp_pkg::queue_item_type q_item;
   logic                     q_pop;

   sxfp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_buffer_last (req_buffer_last),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_item       (push_item)
   );

   sxfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   sxfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_linear_x_word (rsp_linear_x_word),
      .rsp_linear_y_word (rsp_linear_y_word),
      .rsp_angular_word  (rsp_angular_word)
   );

endmodule

### tb/tb_sync_xor_frame_parser.sv
// Self-checking testbench for the sync/XOR frame parser: directed table, then random buffers.
module tb_sync_xor_frame_parser;

   // parser progress within one receive buffer
   typedef enum logic [1:0] {
      MODE_HUNT    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_DONE    = 2'd2
   } frame_mode_type;

   // one decoded frame as it leaves the block
   typedef struct packed {
      logic        ok;
      logic [31:0] lin_x;
      logic [31:0] lin_y;
      logic [31:0] ang;
   } frame_result_type;

   // one row of the directed table; the frame is typed in only where known is set
   typedef struct packed {
      logic [7:0]       rx;
      logic             last;
      logic             known;
      frame_result_type want;
   } stim_row_type;

   localparam int TARGET_ITEMS = 850;
   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        req_buffer_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_frame_ok;
   logic [31:0] rsp_linear_x_word;
   logic [31:0] rsp_linear_y_word;
   logic [31:0] rsp_angular_word;

   // predictor state: a copy of the parser's view of the current buffer
   frame_mode_type frame_mode    = MODE_HUNT;
   bit             seen_sync     = 1'b0;
   int             stored_count  = 0;
   logic [7:0]     xor_acc       = 8'h00;
   logic [7:0]     payload_bytes [sxfp_pkg::PAYLOAD_LEN];

   frame_result_type pending_frames [$];   // frames owed by the block, oldest first
   stim_row_type     directed_rows [$];
   frame_result_type head_frame;

   int mismatch_count = 0;
   int items_used     = 0;   // requests not swallowed after a finished frame
   int bytes_sent     = 0;
   int buffers_sent   = 0;
   int frames_checked = 0;
   int bad_checksums  = 0;
   int send_quiet     = 0;   // remaining requests of a no-gap stretch
   int recv_quiet     = 0;   // remaining responses of a no-stall stretch
   bit drained_once   = 1'b0;

   sync_xor_frame_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_buffer_last   (req_buffer_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_linear_x_word (rsp_linear_x_word),
      .rsp_linear_y_word (rsp_linear_y_word),
      .rsp_angular_word  (rsp_angular_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; well beyond the slowest legal run (every request and response
   // waiting out the longest gap, plus queue back-pressure).
   initial begin
      #5_000_000;
      $display("[sync_xor_frame_parser] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t mismatch, %s: got %h, want %h", $time, what, got, want);
   endtask

   // Advances the predictor by one request. Returns 1 when the request is the
   // checksum byte of a frame, with the decoded frame in fr.
   function automatic bit track_frame(input logic [7:0] rx, input logic last,
                                      output frame_result_type fr);
      bit produced;
      produced = 1'b0;
      fr       = '0;
      case (frame_mode)
         MODE_HUNT: begin
            if (rx == sxfp_pkg::SYNC_BYTE && seen_sync) begin
               frame_mode   = MODE_COLLECT;
               seen_sync    = 1'b0;
               stored_count = 0;
               xor_acc      = 8'h00;
            end else begin
               seen_sync = (rx == sxfp_pkg::SYNC_BYTE);
            end
         end
         MODE_COLLECT: begin
            if (stored_count < sxfp_pkg::PAYLOAD_LEN) begin
               payload_bytes[stored_count] = rx;
               xor_acc = xor_acc ^ rx;
               stored_count++;
            end else begin
               // words are little-endian: lowest frame byte in bits 7:0
               fr.ok    = (xor_acc == rx);
               fr.lin_x = {payload_bytes[3], payload_bytes[2],
                           payload_bytes[1], payload_bytes[0]};
               fr.lin_y = {payload_bytes[7], payload_bytes[6],
                           payload_bytes[5], payload_bytes[4]};
               fr.ang   = {payload_bytes[11], payload_bytes[10],
                           payload_bytes[9], payload_bytes[8]};
               produced   = 1'b1;
               frame_mode = MODE_DONE;
            end
         end
         default: ;   // done for this buffer: bytes ignored
      endcase
      // buffer end always restarts the hunt, dropping any partial frame
      if (last) begin
         frame_mode   = MODE_HUNT;
         seen_sync    = 1'b0;
         stored_count = 0;
         xor_acc      = 8'h00;
      end
      return produced;
   endfunction

   // Wait before the next request or response: often none, otherwise a gap
   // drawn at random, with occasional long stretches of back-to-back traffic.
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 16);
   endfunction

   // Byte values weighted towards the corners and the sync value.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return sxfp_pkg::SYNC_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_row(input logic [7:0] rx, input logic last, input logic known,
                          input frame_result_type want);
      directed_rows.push_back({rx, last, known, want});
   endtask

   // Offers one request, holds it until taken, then books the frame it owes.
   task automatic send_byte(input logic [7:0] rx, input logic last, input logic known,
                            input frame_result_type want);
      int               gap;
      bit               produced;
      frame_result_type fr;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= rx;
      req_buffer_last <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (frame_mode != MODE_DONE)
         items_used++;
      produced = track_frame(rx, last, fr);
      if (known)
         pending_frames.push_back(want);
      else if (produced)
         pending_frames.push_back(fr);
   endtask

   // One random receive buffer. Mostly a well-formed frame with random
   // content; also header-free noise and buffers cut short mid-frame.
   task automatic send_buffer();
      logic [7:0] bytes_q [$];
      logic [7:0] b;
      logic [7:0] sum;
      int         kind;
      kind = $urandom_range(0, 9);
      repeat ($urandom_range(0, 3)) bytes_q.push_back(pick_byte());
      if (kind == 0) begin
         bytes_q.push_back(pick_byte());
      end else begin
         bytes_q.push_back(sxfp_pkg::SYNC_BYTE);
         bytes_q.push_back(sxfp_pkg::SYNC_BYTE);
         sum = 8'h00;
         for (int i = 0; i < sxfp_pkg::PAYLOAD_LEN; i++) begin
            // a sync byte straight after the header is plain payload
            b = (i == 0 && $urandom_range(0, 5) == 0) ? sxfp_pkg::SYNC_BYTE : pick_byte();
            sum = sum ^ b;
            bytes_q.push_back(b);
         end
         bytes_q.push_back(($urandom_range(0, 3) == 0) ? pick_byte() : sum);
         if (kind == 1) begin
            // buffer ends somewhere between header and checksum
            repeat ($urandom_range(1, 13)) void'(bytes_q.pop_back());
         end else if ($urandom_range(0, 1) == 0) begin
            // trailing bytes, ignored once the frame is done
            repeat ($urandom_range(1, 4)) bytes_q.push_back(pick_byte());
         end
      end
      foreach (bytes_q[i])
         send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
      buffers_sent++;
   endtask

   // Response side: stall for a drawn number of cycles, then take one response.
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         hold = draw_wait(recv_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Response checker: every taken response against the oldest booked frame.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("response with no frame pending", rsp_linear_x_word, '0);
         end else begin
            head_frame = pending_frames.pop_front();
            frames_checked++;
            if (!rsp_frame_ok)
               bad_checksums++;
            if (rsp_frame_ok !== head_frame.ok)
               report_mismatch("frame_ok", 32'(rsp_frame_ok), 32'(head_frame.ok));
            if (rsp_linear_x_word !== head_frame.lin_x)
               report_mismatch("linear_x_word", rsp_linear_x_word, head_frame.lin_x);
            if (rsp_linear_y_word !== head_frame.lin_y)
               report_mismatch("linear_y_word", rsp_linear_y_word, head_frame.lin_y);
            if (rsp_angular_word !== head_frame.ang)
               report_mismatch("angular_word", rsp_angular_word, head_frame.ang);
         end
      end
   end

   // Request side and end of run.
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rx_byte     <= 8'h00;
      req_buffer_last <= 1'b0;

      // lone sync byte closing a buffer: no header, nothing owed
      add_row(sxfp_pkg::SYNC_BYTE, 1'b1, 1'b0, '0);
      // header then one payload byte, buffer ends: partial frame dropped
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      add_row(8'h00,               1'b1, 1'b0, '0);
      // three sync bytes in a row: third is payload, then eleven 0xFF;
      // XOR is 0xBB ^ 0xFF = 0x44, so a 0x44 checksum passes
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      repeat (sxfp_pkg::PAYLOAD_LEN - 1) add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h44, 1'b0, 1'b1, {1'b1, 32'hFFFF_FFBB, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      // header inside a finished buffer is ignored up to buffer end
      add_row(sxfp_pkg::SYNC_BYTE, 1'b0, 1'b0, '0);
      add_row(sxfp_pkg::SYNC_BYTE, 1'b1, 1'b0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].last,
                   directed_rows[i].known, directed_rows[i].want);

      while (items_used < TARGET_ITEMS) begin
         // once, halfway: hold requests back until the block has caught up
         if (!drained_once && items_used >= TARGET_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_frames.size() != 0);
            drained_once = 1'b1;
         end
         send_buffer();
      end
      req_valid <= 1'b0;

      while (pending_frames.size() != 0) @(posedge clock);
      // a stray late response would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests in %0d random buffers plus directed rows", bytes_sent,
               buffers_sent);
      $display("%0d frames checked, %0d of them with a failing checksum", frames_checked,
               bad_checksums);
      if (mismatch_count == 0)
         $display("[sync_xor_frame_parser] OK");
      else
         $display("[sync_xor_frame_parser] ERROR");
      $finish;
   end

endmodule
